// ===== rtl/let_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package let_pkg;

    // Geometry limits and derived widths
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int DIM_W      = 11;
    localparam int SLOT_W     = 2;
    localparam int ADDR_W     = SLOT_W + COL_W;
    localparam int RAM_DEPTH  = 3 * MAX_WIDTH;
    localparam int GREY_W     = 8;
    localparam int THR_W      = 8;
    localparam int LAP_W      = GREY_W + 4;

    // Luma weights, Q0.16, and rounding term
    localparam logic [15:0] WGT_RED   = 16'd19595;
    localparam logic [15:0] WGT_GREEN = 16'd38470;
    localparam logic [15:0] WGT_BLUE  = 16'd7471;
    localparam logic [23:0] GREY_RND  = 24'd32768;

    // Request op codes
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] REG_IMAGE_WIDTH    = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT   = 2'd1;
    localparam logic [1:0] REG_EDGE_THRESHOLD = 2'd2;

    // Command passed from the front end to the back end
    typedef struct packed {
        logic                res;
        logic [SLOT_W-1:0]   a_slot;
        logic [SLOT_W-1:0]   b_slot;
        logic [COL_W-1:0]    col;
        logic [COL_W-1:0]    west;
        logic [COL_W-1:0]    east;
        logic                n_is_cen;
        logic                s_is_grey;
        logic [GREY_W-1:0]   grey;
        logic                we;
        logic [SLOT_W-1:0]   w_slot;
        logic [COL_W-1:0]    wcol;
        logic [COL_W-1:0]    out_col;
        logic [ROW_W-1:0]    out_row;
        logic                done;
    } t_cmd;

endpackage

`default_nettype wire

// ===== rtl/let_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module let_ram #(
    parameter int DEPTH  = 3072,
    parameter int WIDTH  = 8,
    parameter int ADDR_W = 12
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output      logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port; read data holds between reads
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/let_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module let_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_valid,
    output      logic                        o_cfg_ready,
    input  wire logic [1:0]                  i_cfg_index,
    input  wire logic [let_pkg::DIM_W-1:0]   i_cfg_data,
    input  wire logic                        i_in_valid,
    output      logic                        o_in_ready,
    input  wire logic                        i_op,
    input  wire logic [7:0]                  i_red_level,
    input  wire logic [7:0]                  i_green_level,
    input  wire logic [7:0]                  i_blue_level,
    input  wire logic                        i_q_ready,
    output      logic                        o_push,
    output      let_pkg::t_cmd               o_cmd,
    output      logic [let_pkg::THR_W-1:0]   o_threshold
);

    // Configuration registers
    logic [let_pkg::DIM_W-1:0]  r_img_width, r_img_height;
    logic [let_pkg::THR_W-1:0]  r_threshold;

    // Scan and drain state
    logic [let_pkg::COL_W-1:0]  r_in_col, n_in_col;
    logic [let_pkg::ROW_W-1:0]  r_in_row, n_in_row;
    logic [let_pkg::SLOT_W-1:0] r_row_slot, n_row_slot;
    logic [let_pkg::COL_W-1:0]  r_drain_col, n_drain_col;
    logic                       r_dr_pending, n_dr_pending;
    logic [let_pkg::DIM_W-1:0]  r_dr_width, n_dr_width;
    logic [let_pkg::ROW_W-1:0]  r_dr_row, n_dr_row;
    logic [let_pkg::SLOT_W-1:0] r_dr_slot, n_dr_slot;
    logic [let_pkg::SLOT_W-1:0] r_dr_north, n_dr_north;

    logic [let_pkg::DIM_W-1:0]  w, h;
    logic [let_pkg::COL_W-1:0]  c;
    logic [let_pkg::ROW_W-1:0]  rr;
    logic [let_pkg::SLOT_W-1:0] cur, prev, prev2;
    logic [23:0]                grey_sum;
    logic [let_pkg::GREY_W-1:0] grey;
    logic                       drain_fire;
    logic [let_pkg::DIM_W-1:0]  d_inc, c_inc, r_inc;
    logic                       d_done;
    let_pkg::t_cmd              cmd;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = i_q_ready;
    assign o_push      = i_in_valid & i_q_ready;
    assign o_cmd       = cmd;
    assign o_threshold = r_threshold;

    // Effective geometry and saturated position
    always_comb begin
        if (r_img_width == '0) begin
            w = let_pkg::DIM_W'(1);
        end else if (r_img_width > let_pkg::DIM_W'(let_pkg::MAX_WIDTH)) begin
            w = let_pkg::DIM_W'(let_pkg::MAX_WIDTH);
        end else begin
            w = r_img_width;
        end
        if (r_img_height == '0) begin
            h = let_pkg::DIM_W'(1);
        end else if (r_img_height > let_pkg::DIM_W'(let_pkg::MAX_HEIGHT)) begin
            h = let_pkg::DIM_W'(let_pkg::MAX_HEIGHT);
        end else begin
            h = r_img_height;
        end
        c  = ({1'b0, r_in_col} < w) ? r_in_col : let_pkg::COL_W'(w - 1'b1);
        rr = ({1'b0, r_in_row} < h) ? r_in_row : let_pkg::ROW_W'(h - 1'b1);
        c_inc = {1'b0, c} + 1'b1;
        r_inc = {1'b0, rr} + 1'b1;
        d_inc = {1'b0, r_drain_col} + 1'b1;
        d_done = d_inc >= r_dr_width;
    end

    // Line buffer slot rotation
    always_comb begin
        cur   = r_row_slot;
        prev  = (cur == 2'd0) ? 2'd2 : cur - 2'd1;
        prev2 = (cur == 2'd2) ? 2'd0 : cur + 2'd1;
    end

    // Grey conversion, rounded Q0.16
    always_comb begin
        grey_sum = 24'(let_pkg::WGT_RED * i_red_level)
                 + 24'(let_pkg::WGT_GREEN * i_green_level)
                 + 24'(let_pkg::WGT_BLUE * i_blue_level)
                 + let_pkg::GREY_RND;
        grey = grey_sum[23:16];
    end

    assign drain_fire = r_dr_pending & ((i_op == let_pkg::OP_DRAIN) | (rr == '0));

    // Classify the request into a back-end command
    always_comb begin
        cmd           = '0;
        cmd.grey      = grey;
        cmd.w_slot    = cur;
        cmd.wcol      = c;
        if (drain_fire) begin
            cmd.res      = 1'b1;
            cmd.a_slot   = r_dr_slot;
            cmd.b_slot   = r_dr_north;
            cmd.col      = r_drain_col;
            cmd.west     = (r_drain_col != '0) ? r_drain_col - 1'b1 : '0;
            cmd.east     = (d_inc < r_dr_width) ? let_pkg::COL_W'(d_inc)
                                                : let_pkg::COL_W'(r_dr_width - 1'b1);
            cmd.out_col  = r_drain_col;
            cmd.out_row  = r_dr_row;
            cmd.done     = d_done;
        end else if ((i_op == let_pkg::OP_PIXEL) && (rr != '0)) begin
            cmd.res       = 1'b1;
            cmd.a_slot    = prev;
            cmd.b_slot    = prev2;
            cmd.col       = c;
            cmd.west      = (c != '0) ? c - 1'b1 : '0;
            cmd.east      = (c_inc < w) ? let_pkg::COL_W'(c_inc)
                                        : let_pkg::COL_W'(w - 1'b1);
            cmd.n_is_cen  = (rr == let_pkg::ROW_W'(1));
            cmd.s_is_grey = 1'b1;
            cmd.out_col   = c;
            cmd.out_row   = rr - 1'b1;
        end
        // The pixel write goes to the current column of the incoming row
        if (i_op == let_pkg::OP_PIXEL) begin
            cmd.we = 1'b1;
        end
    end

    // Next scan and drain state
    always_comb begin
        n_in_col     = r_in_col;
        n_in_row     = r_in_row;
        n_row_slot   = r_row_slot;
        n_drain_col  = r_drain_col;
        n_dr_pending = r_dr_pending;
        n_dr_width   = r_dr_width;
        n_dr_row     = r_dr_row;
        n_dr_slot    = r_dr_slot;
        n_dr_north   = r_dr_north;
        if (drain_fire) begin
            n_drain_col = let_pkg::COL_W'(d_inc);
            if (d_done) begin
                n_dr_pending = 1'b0;
                n_drain_col  = '0;
            end
        end else if (r_dr_pending && (i_op == let_pkg::OP_PIXEL)) begin
            n_dr_pending = 1'b0;
            n_drain_col  = '0;
        end
        if (i_op == let_pkg::OP_PIXEL) begin
            if (c_inc >= w) begin
                if (r_inc >= h) begin
                    n_dr_pending = 1'b1;
                    n_drain_col  = '0;
                    n_dr_width   = w;
                    n_dr_row     = rr;
                    n_dr_slot    = cur;
                    n_dr_north   = (rr != '0) ? prev : cur;
                    n_in_row     = '0;
                end else begin
                    n_in_row = let_pkg::ROW_W'(r_inc);
                end
                n_in_col   = '0;
                n_row_slot = prev2;
            end else begin
                n_in_col = let_pkg::COL_W'(c_inc);
                n_in_row = rr;
            end
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_width  <= let_pkg::DIM_W'(let_pkg::MAX_WIDTH);
            r_img_height <= let_pkg::DIM_W'(let_pkg::MAX_HEIGHT);
            r_threshold  <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                let_pkg::REG_IMAGE_WIDTH:    r_img_width  <= i_cfg_data;
                let_pkg::REG_IMAGE_HEIGHT:   r_img_height <= i_cfg_data;
                let_pkg::REG_EDGE_THRESHOLD: r_threshold  <= i_cfg_data[let_pkg::THR_W-1:0];
                default: ;
            endcase
        end
    end

    // Scan state update on each accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col     <= '0;
            r_in_row     <= '0;
            r_row_slot   <= '0;
            r_drain_col  <= '0;
            r_dr_pending <= 1'b0;
            r_dr_width   <= '0;
            r_dr_row     <= '0;
            r_dr_slot    <= '0;
            r_dr_north   <= '0;
        end else if (o_push) begin
            r_in_col     <= n_in_col;
            r_in_row     <= n_in_row;
            r_row_slot   <= n_row_slot;
            r_drain_col  <= n_drain_col;
            r_dr_pending <= n_dr_pending;
            r_dr_width   <= n_dr_width;
            r_dr_row     <= n_dr_row;
            r_dr_slot    <= n_dr_slot;
            r_dr_north   <= n_dr_north;
        end
    end

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row_slot != 2'd3)
        else $error("row slot out of range");
    a_drain_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dr_pending |-> ({1'b0, r_drain_col} < r_dr_width))
        else $error("drain column beyond latched width");
    a_drain_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dr_pending |-> (r_dr_slot != r_row_slot))
        else $error("drained row shares the slot being written");

endmodule

`default_nettype wire

// ===== rtl/let_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module let_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire let_pkg::t_cmd i_cmd,
    output      logic          o_ready,
    input  wire logic          i_pop,
    output      logic          o_valid,
    output      let_pkg::t_cmd o_cmd
);

    let_pkg::t_cmd r_ent [0:1];
    logic          r_wptr, r_rptr;
    logic [1:0]    r_count;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_ent[r_rptr];

    // Two-entry command queue
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && (r_count == 2'd2)))
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && (r_count == 2'd0)))
        else $error("pop from empty queue");
    a_count_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd1) |-> (r_wptr != r_rptr))
        else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

// ===== rtl/let_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module let_back (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_q_valid,
    input  wire let_pkg::t_cmd              i_cmd,
    output      logic                       o_pop,
    input  wire logic [let_pkg::THR_W-1:0]  i_threshold,
    output      logic                       o_out_valid,
    input  wire logic                       i_out_ready,
    output      logic                       o_edge_on,
    output      logic [let_pkg::COL_W-1:0]  o_out_column,
    output      logic [let_pkg::ROW_W-1:0]  o_out_row,
    output      logic                       o_frame_done
);

    logic [let_pkg::GREY_W-1:0] cen_q, west_q, east_q, north_q;
    logic [let_pkg::ADDR_W-1:0] waddr;
    logic                       wen;

    // Stage B: command waiting for its read data
    logic                       r_b_valid;
    logic                       r_b_res;
    logic                       r_b_n_is_cen, r_b_s_is_grey;
    logic [let_pkg::GREY_W-1:0] r_b_grey;
    logic [let_pkg::COL_W-1:0]  r_b_col;
    logic [let_pkg::ROW_W-1:0]  r_b_row;
    logic                       r_b_done;

    // Output register
    logic                       r_o_valid, r_o_edge, r_o_done;
    logic [let_pkg::COL_W-1:0]  r_o_col;
    logic [let_pkg::ROW_W-1:0]  r_o_row;

    logic                       out_free, b_adv, b_load;
    logic [let_pkg::GREY_W-1:0] north, south;
    logic signed [let_pkg::LAP_W-1:0] lap;
    logic                       edge_bit;

    assign out_free = ~r_o_valid | i_out_ready;
    assign b_adv    = r_b_valid & (~r_b_res | out_free);
    assign o_pop    = i_q_valid & (~r_b_valid | b_adv);
    assign b_load   = r_b_valid & r_b_res & out_free;
    assign wen      = o_pop & i_cmd.we;
    assign waddr    = {i_cmd.w_slot, i_cmd.wcol};

    // Four copies of the line buffers, one per tap read from them: centre, west, east, north
    let_ram #(.DEPTH(let_pkg::RAM_DEPTH), .WIDTH(let_pkg::GREY_W),
              .ADDR_W(let_pkg::ADDR_W)) u_ram_cen (
        .i_clk(i_clk), .i_we(wen), .i_waddr(waddr), .i_wdata(i_cmd.grey),
        .i_re(o_pop), .i_raddr({i_cmd.a_slot, i_cmd.col}), .o_rdata(cen_q));
    let_ram #(.DEPTH(let_pkg::RAM_DEPTH), .WIDTH(let_pkg::GREY_W),
              .ADDR_W(let_pkg::ADDR_W)) u_ram_west (
        .i_clk(i_clk), .i_we(wen), .i_waddr(waddr), .i_wdata(i_cmd.grey),
        .i_re(o_pop), .i_raddr({i_cmd.a_slot, i_cmd.west}), .o_rdata(west_q));
    let_ram #(.DEPTH(let_pkg::RAM_DEPTH), .WIDTH(let_pkg::GREY_W),
              .ADDR_W(let_pkg::ADDR_W)) u_ram_east (
        .i_clk(i_clk), .i_we(wen), .i_waddr(waddr), .i_wdata(i_cmd.grey),
        .i_re(o_pop), .i_raddr({i_cmd.a_slot, i_cmd.east}), .o_rdata(east_q));
    let_ram #(.DEPTH(let_pkg::RAM_DEPTH), .WIDTH(let_pkg::GREY_W),
              .ADDR_W(let_pkg::ADDR_W)) u_ram_north (
        .i_clk(i_clk), .i_we(wen), .i_waddr(waddr), .i_wdata(i_cmd.grey),
        .i_re(o_pop), .i_raddr({i_cmd.b_slot, i_cmd.col}), .o_rdata(north_q));

    // Cross Laplacian and threshold compare
    always_comb begin
        north = r_b_n_is_cen ? cen_q : north_q;
        south = r_b_s_is_grey ? r_b_grey : cen_q;
        lap   = $signed({2'b00, cen_q, 2'b00})
              - $signed(let_pkg::LAP_W'(north))
              - $signed(let_pkg::LAP_W'(south))
              - $signed(let_pkg::LAP_W'(east_q))
              - $signed(let_pkg::LAP_W'(west_q));
        edge_bit = lap > $signed(let_pkg::LAP_W'(i_threshold));
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_b_res       <= i_cmd.res;
            r_b_n_is_cen  <= i_cmd.n_is_cen;
            r_b_s_is_grey <= i_cmd.s_is_grey;
            r_b_grey      <= i_cmd.grey;
            r_b_col       <= i_cmd.out_col;
            r_b_row       <= i_cmd.out_row;
            r_b_done      <= i_cmd.done;
        end
        if (b_load) begin
            r_o_edge <= edge_bit;
            r_o_col  <= r_b_col;
            r_o_row  <= r_b_row;
            r_o_done <= r_b_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_b_valid <= 1'b1;
            end else if (b_adv) begin
                r_b_valid <= 1'b0;
            end
            if (b_load) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_o_valid;
    assign o_edge_on    = r_o_edge;
    assign o_out_column = r_o_col;
    assign o_out_row    = r_o_row;
    assign o_frame_done = r_o_done;

    a_pop_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (!r_b_valid || b_adv))
        else $error("stage B overwritten while holding a command");
    a_load_from_b: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_load |-> out_free)
        else $error("output register overwritten before it was taken");
    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && r_b_res && !out_free) |=> (r_b_valid && $stable(r_b_col)))
        else $error("stalled stage B command lost");

endmodule

`default_nettype wire

// ===== rtl/laplacian_edge_threshold_core.sv =====
// Path: a result passes through the command queue, stage B and the output register.
// Throughput: one request per clock, pixel or drain, set by the single write port of the
// line buffers; a result waiting on the output does not stop intake until the queue fills.
// Reset: synchronous, active low; clears scan, drain and handshake state and the registers
// to their defaults. Line buffer contents are not cleared and no clearing pass is run.
`timescale 1ns / 1ps
`default_nettype none

module laplacian_edge_threshold_core (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_valid,
    output      logic                       o_cfg_ready,
    input  wire logic [1:0]                 i_cfg_index,
    input  wire logic [let_pkg::DIM_W-1:0]  i_cfg_data,
    input  wire logic                       i_in_valid,
    output      logic                       o_in_ready,
    input  wire logic                       i_op,
    input  wire logic [7:0]                 i_red_level,
    input  wire logic [7:0]                 i_green_level,
    input  wire logic [7:0]                 i_blue_level,
    output      logic                       o_out_valid,
    input  wire logic                       i_out_ready,
    output      logic                       o_edge_on,
    output      logic [let_pkg::COL_W-1:0]  o_out_column,
    output      logic [let_pkg::ROW_W-1:0]  o_out_row,
    output      logic                       o_frame_done
);

    let_pkg::t_cmd             push_cmd, pop_cmd;
    logic                      push, q_ready, q_valid, pop;
    logic [let_pkg::THR_W-1:0] threshold;

    // Front end: geometry, drain bookkeeping, grey conversion
    let_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_op(i_op), .i_red_level(i_red_level),
        .i_green_level(i_green_level), .i_blue_level(i_blue_level),
        .i_q_ready(q_ready), .o_push(push), .o_cmd(push_cmd),
        .o_threshold(threshold));

    // Decoupling queue
    let_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(push), .i_cmd(push_cmd), .o_ready(q_ready),
        .i_pop(pop), .o_valid(q_valid), .o_cmd(pop_cmd));

    // Back end: line buffers, stencil, output register
    let_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_q_valid(q_valid), .i_cmd(pop_cmd), .o_pop(pop),
        .i_threshold(threshold),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_edge_on(o_edge_on), .o_out_column(o_out_column),
        .o_out_row(o_out_row), .o_frame_done(o_frame_done));

endmodule

`default_nettype wire
